// File: sv/fsbd_pkg.sv
// Shared types, constants and the percent scaling function of the
// force-sensor button debouncer. No dependencies.
package fsbd_pkg;

    localparam int SAMPLE_W  = 10;
    localparam int TIME_W    = 32;
    localparam int PCT_W     = 7;
    localparam int COUNT_W   = 32;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W    = 17;
    localparam int REM_W     = 11;

    localparam logic [PROD_W-1:0] PCT_SCALE = PROD_W'(100);
    localparam logic [REM_W-1:0]  FULL_SCALE = REM_W'(1023);

    localparam logic [PCT_W-1:0]   THRESHOLD_RST = PCT_W'(50);
    localparam logic [TIME_W-1:0]  DEBOUNCE_RST  = '0;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_THRESHOLD = 2'd0;
    localparam cfg_idx_t REG_DEBOUNCE  = 2'd1;
    localparam cfg_idx_t REG_MODE      = 2'd2;

    typedef enum logic [MODE_W-1:0] {
        CNT_BOTH = 2'd0,
        CNT_FALL = 2'd1,
        CNT_RISE = 2'd2
    } count_mode_t;

    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_CLEAR  = 1'b1
    } kind_t;

    typedef struct packed {
        logic [PCT_W-1:0]   level_percent;
        logic               raw_pressed;
        logic               steady_pressed;
        logic               press_event;
        logic               release_event;
        logic [COUNT_W-1:0] edge_count;
    } result_t;

    // floor(sample*100/1023): divide by 1024, then correct once
    function automatic logic [PCT_W-1:0] pct_of(input logic [SAMPLE_W-1:0] sample);
        logic [PROD_W-1:0] prod;
        logic [PCT_W-1:0]  q0;
        logic [REM_W-1:0]  rem;
        prod = PROD_W'(sample) * PCT_SCALE;
        q0   = prod[PROD_W-1:10];
        rem  = REM_W'(prod[9:0]) + REM_W'(q0);
        if (rem >= FULL_SCALE)
        begin
            pct_of = q0 + PCT_W'(1);
        end
        else
        begin
            pct_of = q0;
        end
    endfunction

endpackage

// File: sv/fsbd_if.sv
// Handshake channels of the force-sensor button debouncer: sensor requests,
// results and register writes. Depends on fsbd_pkg.
interface fsbd_in_if import fsbd_pkg::*;;
    logic                valid;
    logic                ready;
    logic                kind;
    logic [SAMPLE_W-1:0] sample;
    logic [TIME_W-1:0]   now_ms;

    modport source (output valid, kind, sample, now_ms, input ready);
    modport sink   (input valid, kind, sample, now_ms, output ready);
endinterface

interface fsbd_out_if import fsbd_pkg::*;;
    logic               valid;
    logic               ready;
    logic [PCT_W-1:0]   level_percent;
    logic               raw_pressed;
    logic               steady_pressed;
    logic               press_event;
    logic               release_event;
    logic [COUNT_W-1:0] edge_count;

    modport source (output valid, level_percent, raw_pressed, steady_pressed,
                    press_event, release_event, edge_count, input ready);
    modport sink   (input valid, level_percent, raw_pressed, steady_pressed,
                    press_event, release_event, edge_count, output ready);
endinterface

interface fsbd_cfg_if import fsbd_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CFG_IDX_W-1:0] index;
    logic [TIME_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/force_sensor_button_debouncer.sv
// Top level of the force-sensor button debouncer: scaling, threshold, time
// debounce and edge counter. Depends on fsbd_pkg and the channels in fsbd_if.
//
//  channel  dir  handshake      payload
//  sensor   in   valid/ready    kind, sample, now_ms
//  result   out  valid/ready    level_percent .. edge_count
//  cfg      in   valid/ready    index, data (ready always high)
//
// One request per cycle while the result side is not stalled; a taken request
// passes the input register, then the result register around one
// compare-and-update, before its result is offered.
// A stalled result holds the result register; the input register still takes
// one more request. rst_n clears state to released at time 0 and registers
// to their defaults.
module force_sensor_button_debouncer import fsbd_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    fsbd_in_if.sink     sensor,
    fsbd_out_if.source  result,
    fsbd_cfg_if.sink    cfg
);

    logic [PCT_W-1:0]   threshold_reg;
    logic [TIME_W-1:0]  debounce_reg;
    count_mode_t        mode_reg;

    logic               flicker_reg;
    logic [TIME_W-1:0]  last_change_reg;
    logic               steady_reg;
    logic [COUNT_W-1:0] counter_reg;

    logic               in_valid_reg;
    logic               in_kind_reg;
    logic [SAMPLE_W-1:0] in_sample_reg;
    logic [TIME_W-1:0]  in_now_reg;

    logic               out_valid_reg;
    result_t            out_reg;

    logic               advance;
    logic               take;
    logic               fire;

    logic [PCT_W-1:0]   pct;
    logic               raw;
    logic               flick_chg;
    logic [TIME_W-1:0]  elapsed;
    logic               settle;
    logic               count_hit;
    logic               flicker_next;
    logic [TIME_W-1:0]  last_change_next;
    logic               steady_next;
    logic [COUNT_W-1:0] counter_next;
    result_t            out_next;

    assign advance      = !out_valid_reg || result.ready;
    assign sensor.ready = !in_valid_reg || advance;
    assign take         = sensor.valid && sensor.ready;
    assign fire         = in_valid_reg && advance;
    assign cfg.ready    = 1'b1;

    always_comb
    begin
        pct       = pct_of(in_sample_reg);
        raw       = (pct >= threshold_reg);
        flick_chg = (raw != flicker_reg);
        elapsed   = flick_chg ? '0 : (in_now_reg - last_change_reg);
        settle    = (elapsed >= debounce_reg) && (raw != steady_reg);
        unique case (mode_reg)
            CNT_BOTH: count_hit = 1'b1;
            CNT_FALL: count_hit = !raw;
            CNT_RISE: count_hit = raw;
            default:  count_hit = 1'b0;
        endcase

        flicker_next     = flicker_reg;
        last_change_next = last_change_reg;
        steady_next      = steady_reg;
        counter_next     = counter_reg;
        out_next         = '0;

        if (in_kind_reg == KIND_CLEAR)
        begin
            counter_next = '0;
        end
        else
        begin
            if (flick_chg)
            begin
                flicker_next     = raw;
                last_change_next = in_now_reg;
            end
            if (settle)
            begin
                steady_next = raw;
                if (count_hit)
                begin
                    counter_next = counter_reg + COUNT_W'(1);
                end
            end
            out_next.level_percent = pct;
            out_next.raw_pressed   = raw;
            out_next.press_event   = settle && raw;
            out_next.release_event = settle && !raw;
        end
        out_next.steady_pressed = steady_next;
        out_next.edge_count     = counter_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg   <= THRESHOLD_RST;
            debounce_reg    <= DEBOUNCE_RST;
            mode_reg        <= CNT_FALL;
            flicker_reg     <= 1'b0;
            last_change_reg <= '0;
            steady_reg      <= 1'b0;
            counter_reg     <= '0;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_THRESHOLD: threshold_reg <= cfg.data[PCT_W-1:0];
                    REG_DEBOUNCE:  debounce_reg  <= cfg.data;
                    REG_MODE:      mode_reg      <= count_mode_t'(cfg.data[MODE_W-1:0]);
                    default:       ;
                endcase
            end
            if (sensor.ready)
            begin
                in_valid_reg <= sensor.valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire)
            begin
                flicker_reg     <= flicker_next;
                last_change_reg <= last_change_next;
                steady_reg      <= steady_next;
                counter_reg     <= counter_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_kind_reg   <= sensor.kind;
            in_sample_reg <= sensor.sample;
            in_now_reg    <= sensor.now_ms;
        end
        if (fire)
        begin
            out_reg <= out_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.level_percent  = out_reg.level_percent;
    assign result.raw_pressed    = out_reg.raw_pressed;
    assign result.steady_pressed = out_reg.steady_pressed;
    assign result.press_event    = out_reg.press_event;
    assign result.release_event  = out_reg.release_event;
    assign result.edge_count     = out_reg.edge_count;

endmodule

// File: verif/force_sensor_button_debouncer_tb.sv
// Self-checking testbench for force_sensor_button_debouncer: directed and random sensor
// requests, register writes and back-pressure, checked against an in-bench predictor.
// Depends on fsbd_pkg, the channels in fsbd_if and the debouncer top level.
module force_sensor_button_debouncer_tb;
    import fsbd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned PCT_FULL    = 100;
    localparam int unsigned ADC_FULL    = 1023;
    localparam logic [MODE_W-1:0]   CNT_NONE = 2'd3;
    localparam logic [SAMPLE_W-1:0] ADC_MAX  = 10'h3FF;
    localparam logic [TIME_W-1:0]   MS_MAX   = 32'hFFFF_FFFF;

    logic clk;
    logic rst_n;

    fsbd_in_if  sensor_ch ();
    fsbd_out_if result_ch ();
    fsbd_cfg_if cfg_ch ();

    force_sensor_button_debouncer uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sensor (sensor_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    logic [PCT_W-1:0]   thr_reg;
    logic [TIME_W-1:0]  debounce_reg;
    logic [MODE_W-1:0]  mode_reg;
    logic               flicker_q;
    logic               steady_q;
    logic [TIME_W-1:0]  change_stamp;
    logic [COUNT_W-1:0] edge_tally;

    result_t button_reports[$];

    int unsigned mismatches      = 0;
    int unsigned requests_taken  = 0;
    int unsigned results_checked = 0;
    int unsigned press_seen      = 0;
    int unsigned release_seen    = 0;
    int unsigned cycle_count     = 0;
    int unsigned send_idle_pct   = 0;
    int unsigned recv_idle_pct   = 0;
    int unsigned hold_left       = 0;
    logic        hold_go         = 1'b0;
    logic        hold_seen       = 1'b0;
    logic [TIME_W-1:0] ms_clock  = '0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, button_reports.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic [PCT_W-1:0] level_of(input logic [SAMPLE_W-1:0] reading);
        return PCT_W'((int'(reading) * PCT_FULL) / ADC_FULL);
    endfunction

    function automatic result_t predict_button(input kind_t kind,
                                               input logic [SAMPLE_W-1:0] reading,
                                               input logic [TIME_W-1:0] now);
        result_t           r;
        logic [PCT_W-1:0]  lvl;
        logic              raw;
        logic [TIME_W-1:0] held;
        r = '0;
        if (kind == KIND_CLEAR)
        begin
            edge_tally = '0;
        end
        else
        begin
            lvl = level_of(reading);
            raw = (lvl >= thr_reg);
            if (raw != flicker_q)
            begin
                change_stamp = now;
                flicker_q    = raw;
            end
            held = now - change_stamp;
            if (held >= debounce_reg && raw != steady_q)
            begin
                r.press_event   = raw;
                r.release_event = !raw;
                steady_q        = raw;
                if (mode_reg == CNT_BOTH || (mode_reg == CNT_FALL && !raw) ||
                    (mode_reg == CNT_RISE && raw))
                begin
                    edge_tally = edge_tally + 1'b1;
                end
            end
            r.level_percent = lvl;
            r.raw_pressed   = raw;
        end
        r.steady_pressed = steady_q;
        r.edge_count     = edge_tally;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [COUNT_W-1:0] exp_v,
                               input logic [COUNT_W-1:0] got_v);
        if (got_v !== exp_v)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            if (button_reports.size() == 0)
            begin
                $display("%0t: result expected none actual level %0d count %0d",
                         $time, result_ch.level_percent, result_ch.edge_count);
                mismatches++;
            end
            else
            begin
                want = button_reports.pop_front();
                results_checked++;
                check_field("level_percent", COUNT_W'(want.level_percent),
                            COUNT_W'(result_ch.level_percent));
                check_field("raw_pressed", COUNT_W'(want.raw_pressed),
                            COUNT_W'(result_ch.raw_pressed));
                check_field("steady_pressed", COUNT_W'(want.steady_pressed),
                            COUNT_W'(result_ch.steady_pressed));
                check_field("press_event", COUNT_W'(want.press_event),
                            COUNT_W'(result_ch.press_event));
                check_field("release_event", COUNT_W'(want.release_event),
                            COUNT_W'(result_ch.release_event));
                check_field("edge_count", want.edge_count, result_ch.edge_count);
            end
        end
        if (rst_n && sensor_ch.valid === 1'b1 && sensor_ch.ready === 1'b1)
        begin
            want = predict_button(kind_t'(sensor_ch.kind), sensor_ch.sample,
                                  sensor_ch.now_ms);
            button_reports.push_back(want);
            requests_taken++;
            press_seen   += want.press_event;
            release_seen += want.release_event;
        end
    end

    // hold the result side off for a counted stretch when asked, else stall at random
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            result_ch.ready <= 1'b0;
            hold_left       <= hold_left - 1;
        end
        else if (hold_go != hold_seen)
        begin
            hold_seen       <= hold_go;
            hold_left       <= HOLD_CYCLES;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_req(input kind_t kind, input logic [SAMPLE_W-1:0] reading,
                            input logic [TIME_W-1:0] now);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sensor_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sensor_ch.valid  <= 1'b1;
        sensor_ch.kind   <= kind;
        sensor_ch.sample <= reading;
        sensor_ch.now_ms <= now;
        do
            @(posedge clk);
        while (sensor_ch.ready !== 1'b1);
    endtask

    task automatic settle();
        sensor_ch.valid <= 1'b0;
        @(posedge clk);
        while (button_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [TIME_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        case (idx)
            REG_THRESHOLD: thr_reg      = value[PCT_W-1:0];
            REG_DEBOUNCE:  debounce_reg = value;
            REG_MODE:      mode_reg     = value[MODE_W-1:0];
            default:       ;
        endcase
    endtask

    task automatic configure(input logic [PCT_W-1:0] thr, input logic [TIME_W-1:0] deb,
                             input logic [MODE_W-1:0] mode);
        settle();
        write_reg(REG_THRESHOLD, TIME_W'(thr));
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_MODE, TIME_W'(mode));
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] reading_for(input logic pressed);
        logic [SAMPLE_W-1:0] pick;
        pick = SAMPLE_W'($urandom_range(ADC_FULL));
        for (int i = 0; i < 12 && ((level_of(pick) >= thr_reg) != pressed); i++)
            pick = SAMPLE_W'($urandom_range(ADC_FULL));
        return pick;
    endfunction

    task automatic test_reset_defaults();
        send_req(KIND_SAMPLE, '0, '0);
        send_req(KIND_SAMPLE, 10'd511, 32'd1);
        send_req(KIND_SAMPLE, 10'd512, 32'd2);
        send_req(KIND_SAMPLE, ADC_MAX, 32'd3);
        send_req(KIND_SAMPLE, '0, 32'd4);
        send_req(KIND_CLEAR, ADC_MAX, MS_MAX);
    endtask

    task automatic test_threshold_limits();
        configure('0, '0, CNT_FALL);
        send_req(KIND_SAMPLE, '0, 32'd10);
        configure(PCT_W'(PCT_FULL), '0, CNT_FALL);
        send_req(KIND_SAMPLE, 10'd1022, 32'd11);
        send_req(KIND_SAMPLE, ADC_MAX, 32'd12);
        configure(7'h7F, '0, CNT_FALL);
        send_req(KIND_SAMPLE, ADC_MAX, 32'd13);
    endtask

    task automatic test_count_modes();
        logic [MODE_W-1:0] modes[4];
        modes = '{CNT_BOTH, CNT_RISE, CNT_NONE, CNT_FALL};
        ms_clock = 32'd100;
        foreach (modes[m])
        begin
            configure(7'd50, '0, modes[m]);
            send_req(KIND_SAMPLE, ADC_MAX, ms_clock);
            send_req(KIND_SAMPLE, '0, ms_clock + 1);
            ms_clock += 2;
        end
    endtask

    task automatic test_debounce_window();
        logic [TIME_W-1:0] base;
        base = MS_MAX - 15;
        configure(7'd50, 32'd20, CNT_BOTH);
        send_req(KIND_SAMPLE, ADC_MAX, base);
        send_req(KIND_SAMPLE, '0, base + 5);
        send_req(KIND_SAMPLE, ADC_MAX, base + 8);
        send_req(KIND_SAMPLE, ADC_MAX, base + 27);
        send_req(KIND_SAMPLE, ADC_MAX, base + 28);
        configure(7'd50, MS_MAX, CNT_BOTH);
        send_req(KIND_SAMPLE, '0, 32'd1000);
        send_req(KIND_SAMPLE, '0, 32'd998);
        send_req(KIND_SAMPLE, '0, 32'd999);
    endtask

    task automatic test_random_traffic(input int unsigned tx_idle, input int unsigned rx_idle,
                                       input int unsigned count);
        int unsigned       sent;
        int unsigned       roll;
        logic              target;
        logic [PCT_W-1:0]  thr_pick;
        sent = 0;
        settle();
        send_idle_pct = tx_idle;
        recv_idle_pct <= rx_idle;
        while (sent < count)
        begin
            if (sent % 200 == 0)
            begin
                thr_pick = ($urandom_range(9) == 0) ? PCT_W'($urandom_range(127))
                                                    : PCT_W'($urandom_range(20, 80));
                configure(thr_pick, TIME_W'($urandom_range(40)),
                          MODE_W'($urandom_range(3)));
                ms_clock = ($urandom_range(3) == 0) ? MS_MAX - $urandom_range(200)
                                                    : $urandom();
            end
            roll = $urandom_range(99);
            if (roll < 5)
            begin
                send_req(KIND_CLEAR, SAMPLE_W'($urandom()), $urandom());
                sent++;
            end
            else if (roll < 10)
            begin
                ms_clock = $urandom();
                send_req(KIND_SAMPLE, SAMPLE_W'($urandom()), ms_clock);
                sent++;
            end
            else
            begin
                target = 1'($urandom_range(1));
                repeat ($urandom_range(4))
                begin
                    ms_clock += $urandom_range(3);
                    send_req(KIND_SAMPLE, reading_for(1'($urandom_range(1))), ms_clock);
                    sent++;
                end
                repeat ($urandom_range(1, 6))
                begin
                    ms_clock += $urandom_range(debounce_reg / 2 + 2);
                    send_req(KIND_SAMPLE, reading_for(target), ms_clock);
                    sent++;
                end
            end
        end
    endtask

    task automatic test_result_backpressure();
        settle();
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        configure(7'd50, 32'd5, CNT_BOTH);
        hold_go <= ~hold_go;
        repeat (40)
        begin
            ms_clock += $urandom_range(4);
            send_req(KIND_SAMPLE, reading_for(1'($urandom_range(1))), ms_clock);
        end
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        sensor_ch.valid  <= 1'b0;
        sensor_ch.kind   <= KIND_SAMPLE;
        sensor_ch.sample <= '0;
        sensor_ch.now_ms <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= REG_THRESHOLD;
        cfg_ch.data      <= '0;
        thr_reg      = THRESHOLD_RST;
        debounce_reg = DEBOUNCE_RST;
        mode_reg     = CNT_FALL;
        flicker_q    = 1'b0;
        steady_q     = 1'b0;
        change_stamp = '0;
        edge_tally   = '0;
        send_idle_pct = 16;
        recv_idle_pct = 60;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_threshold_limits();
        test_count_modes();
        test_debounce_window();
        test_random_traffic(16, 60, 600);
        test_random_traffic(60, 16, 600);
        test_random_traffic(0, 0, 600);
        test_result_backpressure();

        settle();
        repeat (8) @(posedge clk);
        $display("covered %0d requests and %0d checked results, with %0d press and %0d release",
                 requests_taken, results_checked, press_seen, release_seen);
        $display("pulses across thresholds 0..127, debounce 0..max with time wrap, all count modes");
        if (mismatches == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
